// ===== design/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   // one classified byte: up to two alphabet indices
   typedef struct packed {
      logic [5:0] sym0;
      logic [5:0] sym1;
      logic       two;
      logic       last;
   } job_type;

   localparam logic [5:0] IDX_UPPER_END = 6'd26;
   localparam logic [5:0] IDX_LOWER_END = 6'd52;
   localparam logic [5:0] IDX_DIGIT_END = 6'd62;
   localparam logic [5:0] IDX_PLUS      = 6'd62;

   localparam logic [6:0] ASCII_UPPER_A = 7'd65;
   localparam logic [6:0] LOWER_OFFSET  = 7'd71;
   localparam logic [6:0] DIGIT_OFFSET  = 7'd4;
   localparam logic [6:0] ASCII_PLUS    = 7'd43;
   localparam logic [6:0] ASCII_SLASH   = 7'd47;

   function automatic logic [6:0] to_ascii(input logic [5:0] idx);
      logic [6:0] wide;
      wide = {1'b0, idx};
      if (idx < IDX_UPPER_END) begin
         return ASCII_UPPER_A + wide;
      end else if (idx < IDX_LOWER_END) begin
         return LOWER_OFFSET + wide;
      end else if (idx < IDX_DIGIT_END) begin
         return wide - DIGIT_OFFSET;
      end else if (idx == IDX_PLUS) begin
         return ASCII_PLUS;
      end else begin
         return ASCII_SLASH;
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the group phase and leftover bits, and forms jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   output b64e_pkg::job_type     job,
   output logic                  job_push,
   input  wire logic             queue_full
);

   b64e_pkg::phase_type phase_ff, phase_in, phase_next;
   logic [3:0]          carry_ff, carry_in, carry_next;
   logic                take;

   assign take     = push && !queue_full;
   assign job_push = take;

   // next state
   always_comb begin
      unique case (phase_ff)
         b64e_pkg::PHASE_1: begin
            phase_next = b64e_pkg::PHASE_2;
            carry_next = data_byte[3:0];
         end
         b64e_pkg::PHASE_2: begin
            phase_next = b64e_pkg::PHASE_0;
            carry_next = 4'd0;
         end
         default: begin
            phase_next = b64e_pkg::PHASE_1;
            carry_next = {2'b00, data_byte[1:0]};
         end
      endcase
      phase_in = phase_ff;
      carry_in = carry_ff;
      if (take) begin
         if (last_byte) begin
            phase_in = b64e_pkg::PHASE_0;
            carry_in = 4'd0;
         end else begin
            phase_in = phase_next;
            carry_in = carry_next;
         end
      end
   end

   // outputs
   always_comb begin
      job.last = last_byte;
      unique case (phase_ff)
         b64e_pkg::PHASE_1: begin
            job.sym0 = {carry_ff[1:0], data_byte[7:4]};
            job.sym1 = {data_byte[3:0], 2'b00};
            job.two  = last_byte;
         end
         b64e_pkg::PHASE_2: begin
            job.sym0 = {carry_ff[3:0], data_byte[7:6]};
            job.sym1 = data_byte[5:0];
            job.two  = 1'b1;
         end
         default: begin
            job.sym0 = data_byte[7:2];
            job.sym1 = {data_byte[1:0], 4'b0000};
            job.two  = last_byte;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_0;
         carry_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b64e_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output b64e_pkg::job_type      head_job,
   output logic                   empty
);

   b64e_pkg::job_type                  entries_ff [b64e_pkg::QUEUE_DEPTH];
   logic [b64e_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [b64e_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [b64e_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                               do_push, do_pop;

   assign full     = (count_ff == b64e_pkg::QUEUE_CNT_W'(b64e_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Walks each job one character at a time into the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64e_pkg::job_type head_job,
   input  wire logic              queue_empty,
   output logic                   queue_pop,
   output logic [6:0]             char_code,
   output logic                   last_char,
   output logic                   out_empty,
   input  wire logic              out_pop
);

   logic       out_valid_ff, out_valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       sel_ff, sel_in;
   logic       load, take;

   assign load = !out_valid_ff || out_pop;
   assign take = load && !queue_empty;

   assign queue_pop = take && (sel_ff || !head_job.two);
   assign out_empty = !out_valid_ff;
   assign char_code = char_ff;
   assign last_char = last_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      sel_in       = sel_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (take) begin
         out_valid_in = 1'b1;
         if (sel_ff) begin
            char_in = b64e_pkg::to_ascii(head_job.sym1);
            last_in = head_job.last;
            sel_in  = 1'b0;
         end else begin
            char_in = b64e_pkg::to_ascii(head_job.sym0);
            last_in = head_job.last && !head_job.two;
            sel_in  = head_job.two;
         end
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

// ===== design/base64_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// Unpadded base64 encoder over a byte stream with last-byte marks.
// ----------------------------------------------------------------------------
// usage:
//   input queue: present req_data_byte and req_last_byte with req_push; the
//   word is taken on a clock edge where req_full is low.
//   result queue: while rsp_empty is low, rsp_char_code and rsp_last_char
//   hold the oldest character; raise rsp_pop to take it.
//   each byte yields one or two characters; rsp_last_char marks the final
//   character of a message, and the next byte starts a new message.
//   the first character of a byte passes through a job queue entry and
//   then the result register before it is visible.
//   throughput: one character per cycle at the result register while rsp_pop
//   drains it; bytes keep entering while characters drain.
//   a four-entry job queue parts the byte front end from the character
//   back end; when the receiver stalls, the queue fills and req_full rises.
//   reset (synchronous) empties the queue and the result register and
//   returns the group phase to the start of a message.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [6:0]      rsp_char_code,
   output logic            rsp_last_char
);

   b64e_pkg::job_type new_job, head_job;
   logic              job_push, queue_full, queue_pop, queue_empty;

   assign req_full = queue_full;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .job        (new_job),
      .job_push   (job_push),
      .queue_full (queue_full)
   );

   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (new_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .char_code   (rsp_char_code),
      .last_char   (rsp_last_char),
      .out_empty   (rsp_empty),
      .out_pop     (rsp_pop)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_encoder_unit. Byte words go in with
// random gaps and messages of random length; every character taken from the
// result queue is checked against an in-bench encoder that tracks the group
// phase and the leftover bits, one queued character per predicted output.
// ----------------------------------------------------------------------------

module tb;

   localparam logic [8*64-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int DEFAULT_IDLE_PCT = 36;
   localparam int MAX_REPORTS      = 10;
   localparam int DRAIN_CYCLES     = 20;

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } b64_char_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [6:0] rsp_char_code;
   logic       rsp_last_char;

   b64_char_type        pending_chars[$];
   b64e_pkg::phase_type enc_phase;
   logic [3:0]          enc_carry;
   int                  src_idle_pct;
   int                  dst_idle_pct;
   int                  error_count;

   base64_stream_encoder_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   always #4 clock = ~clock;

   function automatic logic [6:0] b64_char(input logic [5:0] idx);
      logic [7:0] ch;
      ch = B64_ALPHABET[8 * (63 - idx) +: 8];
      return ch[6:0];
   endfunction

   // encoder model: queues the characters one accepted word produces
   task automatic encode_word(input logic [7:0] b, input logic last);
      b64_char_type c0;
      b64_char_type c1;
      c0.last = 1'b0;
      c1.last = 1'b1;
      case (enc_phase)
         b64e_pkg::PHASE_1: begin
            c0.code = b64_char({enc_carry[1:0], b[7:4]});
            pending_chars.push_back(c0);
            if (last) begin
               c1.code = b64_char({b[3:0], 2'b00});
               pending_chars.push_back(c1);
            end
            enc_carry = b[3:0];
            enc_phase = b64e_pkg::PHASE_2;
         end
         b64e_pkg::PHASE_2: begin
            c0.code = b64_char({enc_carry, b[7:6]});
            c1.code = b64_char(b[5:0]);
            c1.last = last;
            pending_chars.push_back(c0);
            pending_chars.push_back(c1);
            enc_carry = 4'd0;
            enc_phase = b64e_pkg::PHASE_0;
         end
         default: begin
            c0.code = b64_char(b[7:2]);
            pending_chars.push_back(c0);
            if (last) begin
               c1.code = b64_char({b[1:0], 4'b0000});
               pending_chars.push_back(c1);
            end
            enc_carry = {2'b00, b[1:0]};
            enc_phase = b64e_pkg::PHASE_1;
         end
      endcase
      if (last) begin
         enc_phase = b64e_pkg::PHASE_0;
         enc_carry = 4'd0;
      end
   endtask

   // result side: random pops, check before predict so both see pre-edge values
   always @(posedge clock) begin
      b64_char_type want;
      rsp_pop <= ($urandom_range(99) >= dst_idle_pct);
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_chars.size() == 0) begin
            if (error_count < MAX_REPORTS) begin
               $display("unexpected char: code %h last %b", rsp_char_code, rsp_last_char);
            end
            error_count = error_count + 1;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_code !== want.code || rsp_last_char !== want.last) begin
               if (error_count < MAX_REPORTS) begin
                  $display("char mismatch: expected code %h last %b, got code %h last %b",
                           want.code, want.last, rsp_char_code, rsp_last_char);
               end
               error_count = error_count + 1;
            end
         end
      end
      if (!reset && req_push && !req_full) begin
         encode_word(req_data_byte, req_last_byte);
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_push <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_last_byte <= 1'($urandom);
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_word(8'($urandom), (i == len - 1));
      end
   endtask

   task automatic test_edge_bytes();
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      send_word(8'hFC, 1'b0);  send_word(8'h0F, 1'b1);
      send_word(8'h00, 1'b0);  send_word(8'h00, 1'b0);  send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);  send_word(8'hFF, 1'b0);  send_word(8'hFF, 1'b1);
      send_word(8'hFB, 1'b0);  send_word(8'hEF, 1'b0);  send_word(8'hBE, 1'b1);
      send_word(8'h4D, 1'b0);  send_word(8'h61, 1'b0);  send_word(8'h6E, 1'b0);
      send_word(8'h3F, 1'b0);  send_word(8'h80, 1'b1);
      send_word(8'h69, 1'b0);  send_word(8'hA6, 1'b0);  send_word(8'h9A, 1'b0);
      send_word(8'hAA, 1'b0);  send_word(8'h55, 1'b0);  send_word(8'hC3, 1'b1);
   endtask

   task automatic test_random_messages(input int n_words);
      int sent;
      int len;
      sent = 0;
      while (sent < n_words) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(9, 1);
         send_message(len);
         sent = sent + len;
      end
   endtask

   // words with random last marks, so messages end at any phase
   task automatic test_random_marks(input int n_words);
      for (int i = 0; i < n_words; i++) begin
         send_word(8'($urandom), ($urandom_range(2) == 0));
      end
   endtask

   task automatic test_no_idle(input int n_words);
      src_idle_pct = 0;
      dst_idle_pct = 0;
      test_random_messages(n_words);
      src_idle_pct = DEFAULT_IDLE_PCT;
      dst_idle_pct = DEFAULT_IDLE_PCT;
   endtask

   initial begin
      error_count = 0;
      src_idle_pct = DEFAULT_IDLE_PCT;
      dst_idle_pct = DEFAULT_IDLE_PCT;
      enc_phase = b64e_pkg::PHASE_0;
      enc_carry = 4'd0;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      rsp_pop <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_bytes();
      test_random_messages(700);
      test_no_idle(300);
      test_random_marks(300);
      test_random_messages(300);

      req_push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("base64_stream_encoder_unit test passed");
      end else begin
         $display("base64_stream_encoder_unit test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("base64_stream_encoder_unit test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_stream_encoder_unit.sv
tb/tb.sv
